### src/first_fit_heap_allocator_defines.svh
// Assertion helpers for the heap allocator.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define FFA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("allocator check failed");
`define FFA_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) else $error("allocator check failed");
`else
`define FFA_ASSERT(lbl, prop)
`define FFA_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

### src/ffa_pkg.sv
`default_nettype none
package ffa_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 16;
    localparam int OFFSET_BITS  = 16;
    localparam int OFF_W        = OFFSET_BITS;
    localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);

    localparam logic [15:0] HEAP_RESET = 16'd4096;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BADADDR = 2'd3;

    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_SPLIT = 3'd1;
    localparam logic [2:0] CMD_TAKE  = 3'd2;
    localparam logic [2:0] CMD_FREE  = 3'd3;
    localparam logic [2:0] CMD_MNEXT = 3'd4;
    localparam logic [2:0] CMD_MPREV = 3'd5;
    localparam logic [2:0] CMD_MBOTH = 3'd6;

    typedef struct packed {
        logic        mode;
        logic [15:0] request_bytes;
        logic [15:0] release_address;
    } ffa_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] payload_offset;
    } ffa_out_t;

    typedef struct packed {
        logic [OFF_W-1:0] start;
        logic [OFF_W-1:0] size;
        logic             free;
    } cell_data_t;

    typedef struct packed {
        logic             init;
        logic             eval;
        logic             apply;
        logic             mode;
        logic [2:0]       cmd;
        logic [OFF_W-1:0] bytes;
        logic [OFF_W-1:0] addr;
    } cell_ctl_t;

    typedef struct packed {
        logic tgt_here;
        logic tgt_left;
        logic tgt_right;
        logic ge_here;
        logic ge_left;
        logic ge_left2;
    } cell_pos_t;

endpackage
`default_nettype wire

### src/ffa_cell.sv
`default_nettype none
module ffa_cell
    import ffa_pkg::*;
(
    input  wire         aclk,
    input  cell_ctl_t   ctl,
    input  cell_data_t  init_data,
    input  wire         used,
    input  cell_pos_t   pos,
    input  cell_data_t  left,
    input  cell_data_t  right,
    input  cell_data_t  right2,
    output cell_data_t  data,
    output logic        hit,
    output logic        big
);

    localparam logic [OFF_W-1:0] HB = OFF_W'(HEADER_BYTES);

    cell_data_t data_reg, data_next;
    logic       hit_reg, hit_next;
    logic       big_reg, big_next;

    always_comb begin
        hit_next = hit_reg;
        big_next = big_reg;
        if (ctl.eval) begin
            if (ctl.mode == MODE_ALLOC) begin
                hit_next = used && data_reg.free && (data_reg.size >= ctl.bytes);
            end else begin
                hit_next = used && ((data_reg.start + HB) == ctl.addr);
            end
            big_next = {1'b0, data_reg.size} > ({1'b0, ctl.bytes} + {1'b0, HB});
        end
    end

    always_comb begin
        data_next = data_reg;
        if (ctl.init) begin
            data_next = init_data;
        end else if (ctl.apply) begin
            case (ctl.cmd)
                CMD_SPLIT: begin
                    if (pos.tgt_here) begin
                        data_next.size = ctl.bytes;
                        data_next.free = 1'b0;
                    end else if (pos.tgt_left) begin
                        data_next.start = left.start + HB + ctl.bytes;
                        data_next.size  = left.size - ctl.bytes - HB;
                        data_next.free  = 1'b1;
                    end else if (pos.ge_left2) begin
                        data_next = left;
                    end
                end
                CMD_TAKE: begin
                    if (pos.tgt_here) data_next.free = 1'b0;
                end
                CMD_FREE: begin
                    if (pos.tgt_here) data_next.free = 1'b1;
                end
                CMD_MNEXT: begin
                    if (pos.tgt_here) begin
                        data_next.size = data_reg.size + right.size + HB;
                        data_next.free = 1'b1;
                    end else if (pos.ge_left) begin
                        data_next = right;
                    end
                end
                CMD_MPREV: begin
                    if (pos.tgt_right) begin
                        data_next.size = data_reg.size + right.size + HB;
                    end else if (pos.ge_here) begin
                        data_next = right;
                    end
                end
                CMD_MBOTH: begin
                    // absorb the released block and its free successor
                    if (pos.tgt_right) begin
                        data_next.size = data_reg.size + right.size + right2.size + HB + HB;
                    end else if (pos.ge_here) begin
                        data_next = right2;
                    end
                end
                default: begin
                    data_next = data_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        hit_reg  <= hit_next;
        big_reg  <= big_next;
    end

    assign data = data_reg;
    assign hit  = hit_reg;
    assign big  = big_reg;

endmodule
`default_nettype wire

### src/first_fit_heap_allocator.sv
// First-fit heap allocator. The block table lives in a row of 64 cells, each holding
// one block's start, payload size and free mark and shifting entries to its neighbors
// on a split or merge. For each request the cells compare in parallel,
// the first matching cell is picked, then the row updates in one step while the
// result is loaded into the output register. That step waits while the output
// register still holds an untaken result. A new request is taken once the previous
// one has reached the output register. Writing heap_size (or reset) rebuilds the
// table and answers all later requests against the new heap; the write
// is taken only between requests and wins over a request offered in the same cycle.
`default_nettype none
`include "first_fit_heap_allocator_defines.svh"
module first_fit_heap_allocator
    import ffa_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  ffa_in_t     s_data,
    output logic        m_valid,
    input  wire         m_ready,
    output ffa_out_t    m_data,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [15:0] cfg_data
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EVAL  = 2'd1;
    localparam logic [1:0] S_SEL   = 2'd2;
    localparam logic [1:0] S_APPLY = 2'd3;

    localparam logic [OFF_W-1:0] HB = OFF_W'(HEADER_BYTES);

    logic [1:0]             state_reg, state_next;
    ffa_in_t                in_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [2:0]             cmd_reg;
    logic [MAX_BLOCKS-1:0]  tgt_reg, ge_reg;
    ffa_out_t               res_reg, out_reg;
    logic                   m_valid_reg;

    cell_ctl_t              ctl;
    cell_data_t             cells   [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0]  hit_v, big_v, free_v, used_v;
    logic                   init_now, advance;
    logic [15:0]            hs;
    cell_data_t             head_init;

    assign cfg_ready = (state_reg == S_IDLE);
    assign init_now  = !aresetn || (cfg_valid && cfg_ready);
    assign hs        = aresetn ? cfg_data : HEAP_RESET;
    assign head_init = '{start: '0,
                         size: (hs > 16'(HEADER_BYTES)) ? OFF_W'(hs - 16'(HEADER_BYTES)) : '0,
                         free: 1'b1};

    assign s_ready = (state_reg == S_IDLE) && !cfg_valid;
    assign advance = (state_reg == S_APPLY) && (!m_valid_reg || m_ready);

    always_comb begin
        ctl.init  = init_now;
        ctl.eval  = (state_reg == S_EVAL);
        ctl.apply = advance;
        ctl.mode  = in_reg.mode;
        ctl.cmd   = cmd_reg;
        ctl.bytes = OFF_W'(in_reg.request_bytes);
        ctl.addr  = OFF_W'(in_reg.release_address);
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_BLOCKS; gi++) begin : g_cell
            cell_data_t left_d, right_d, right2_d, init_d;
            cell_pos_t  pos;
            if (gi > 0) begin : g_l
                assign left_d       = cells[gi-1];
                assign pos.tgt_left = tgt_reg[gi-1];
                assign pos.ge_left  = ge_reg[gi-1];
                assign init_d       = '0;
            end else begin : g_l0
                assign left_d       = '0;
                assign pos.tgt_left = 1'b0;
                assign pos.ge_left  = 1'b0;
                assign init_d       = head_init;
            end
            if (gi > 1) begin : g_l2
                assign pos.ge_left2 = ge_reg[gi-2];
            end else begin : g_l20
                assign pos.ge_left2 = 1'b0;
            end
            if (gi < MAX_BLOCKS - 1) begin : g_r
                assign right_d       = cells[gi+1];
                assign pos.tgt_right = tgt_reg[gi+1];
            end else begin : g_r0
                assign right_d       = '0;
                assign pos.tgt_right = 1'b0;
            end
            if (gi < MAX_BLOCKS - 2) begin : g_r2
                assign right2_d = cells[gi+2];
            end else begin : g_r20
                assign right2_d = '0;
            end
            assign pos.tgt_here = tgt_reg[gi];
            assign pos.ge_here  = ge_reg[gi];
            assign used_v[gi]   = (count_reg > CNT_W'(gi));
            assign free_v[gi]   = cells[gi].free;

            ffa_cell u_cell (
                .aclk      (aclk),
                .ctl       (ctl),
                .init_data (init_d),
                .used      (used_v[gi]),
                .pos       (pos),
                .left      (left_d),
                .right     (right_d),
                .right2    (right2_d),
                .data      (cells[gi]),
                .hit       (hit_v[gi]),
                .big       (big_v[gi])
            );
        end
    endgenerate

    // pick the first matching cell and decide the table update
    logic [MAX_BLOCKS-1:0] low, ge;
    logic                  found, free_k, big_k, nxt_free, prv_free;
    logic [OFF_W-1:0]      start_k;
    logic [2:0]            cmd_c;
    logic [1:0]            st_c;
    logic [15:0]           off_c;

    always_comb begin
        found    = |hit_v;
        low      = hit_v & (~hit_v + 1'b1);
        ge       = found ? ~(low - 1'b1) : '0;
        free_k   = |(low & free_v);
        big_k    = |(low & big_v);
        nxt_free = |(low[MAX_BLOCKS-2:0] & free_v[MAX_BLOCKS-1:1] & used_v[MAX_BLOCKS-1:1]);
        prv_free = |(low[MAX_BLOCKS-1:1] & free_v[MAX_BLOCKS-2:0]);
        start_k  = '0;
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            start_k = start_k | (cells[i].start & {OFF_W{low[i]}});
        end
        cmd_c = CMD_NONE;
        st_c  = ST_OK;
        off_c = '0;
        if (in_reg.mode == MODE_ALLOC) begin
            if (in_reg.request_bytes == '0 || !found) begin
                st_c = ST_NOFIT;
            end else if (big_k && count_reg == CNT_W'(MAX_BLOCKS)) begin
                st_c = ST_FULL;
            end else begin
                cmd_c = big_k ? CMD_SPLIT : CMD_TAKE;
                off_c = 16'(start_k + HB);
            end
        end else begin
            if (!found || free_k) begin
                st_c = ST_BADADDR;
            end else if (nxt_free && prv_free) begin
                cmd_c = CMD_MBOTH;
            end else if (nxt_free) begin
                cmd_c = CMD_MNEXT;
            end else if (prv_free) begin
                cmd_c = CMD_MPREV;
            end else begin
                cmd_c = CMD_FREE;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_valid && s_ready) state_next = S_EVAL;
            S_EVAL:  state_next = S_SEL;
            S_SEL:   state_next = S_APPLY;
            S_APPLY: if (advance) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        count_next = count_reg;
        if (init_now) begin
            count_next = CNT_W'(1);
        end else if (advance) begin
            case (cmd_reg)
                CMD_SPLIT: count_next = count_reg + 1'b1;
                CMD_MNEXT, CMD_MPREV: count_next = count_reg - 1'b1;
                CMD_MBOTH: count_next = count_reg - CNT_W'(2);
                default:   count_next = count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            count_reg   <= CNT_W'(1);
            cmd_reg     <= CMD_NONE;
            tgt_reg     <= '0;
            ge_reg      <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == S_SEL) begin
                cmd_reg <= cmd_c;
                tgt_reg <= low;
                ge_reg  <= ge;
            end else if (advance) begin
                // hold the row still until the next request is decided
                cmd_reg <= CMD_NONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) in_reg <= s_data;
        if (state_reg == S_SEL) res_reg <= '{status: st_c, payload_offset: off_c};
        if (advance) out_reg <= res_reg;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    `FFA_ASSERT(a_count_range, count_reg >= CNT_W'(1) && count_reg <= CNT_W'(MAX_BLOCKS))
    `FFA_ASSERT(a_tgt_onehot, $onehot0(tgt_reg))
    `FFA_ASSERT(a_apply_loads, advance |=> m_valid && state_reg == S_IDLE)
    `FFA_ASSERT(a_take_starts, (s_valid && s_ready) |=> state_reg == S_EVAL)

endmodule
`default_nettype wire
